### rtl/core/multidim_array_address_calc_assert.svh
// Assertion macros for the array address calculator.
`ifndef MULTIDIM_ARRAY_ADDRESS_CALC_ASSERT_SVH
`define MULTIDIM_ARRAY_ADDRESS_CALC_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MDAAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MDAAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error(msg);

`endif

### rtl/core/mdaac_pkg.sv
// Shared types and constants of the array address calculator.
package mdaac_pkg;

   localparam int MAX_ARRAYS_DEF = 16;
   localparam int MAX_DIMS_DEF   = 16;

   localparam int WORD_W  = 32;
   localparam int SIZE_W  = 31;
   localparam int ID_W    = 4;
   localparam int DNUM_W  = 5;
   localparam int CMD_W   = 2;
   localparam int IDS_NUM = 1 << ID_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_HEADER = 2'd0,
      CMD_BOUNDS = 2'd1,
      CMD_INDEX  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Operands for one pass through the shared multiplier.
   typedef struct packed {
      logic              en;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } mul_req_type;

endpackage

### rtl/core/mdaac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mdaac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mdaac_mul.sv
// Shared 32x32 multiplier keeping the low word, result registered.
module mdaac_mul (
   input  logic                      clock,
   input  mdaac_pkg::mul_req_type    mul_req,
   output logic [mdaac_pkg::WORD_W-1:0] prod
);

   logic [2*mdaac_pkg::WORD_W-1:0] full_prod;
   logic [mdaac_pkg::WORD_W-1:0]   prod_ff;
   logic [mdaac_pkg::WORD_W-1:0]   prod_in;

   assign full_prod = mul_req.a * mul_req.b;
   assign prod_in   = full_prod[mdaac_pkg::WORD_W-1:0];

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### rtl/core/multidim_array_address_calc.sv
// Row-major element address calculator for a table of array descriptors.
//
// Header (command 0) and bounds (command 1) items take a write step. An index
// item (command 2) takes lookup, multiply and accumulate steps; the one that
// ends a reference adds scale and address steps, waiting in the latter for the
// result register to be taken. Registered descriptor reads and one multiplier
// set the steps; the multiplier serves both Horner step offset*extent and final
// scale by element size. Addresses wrap modulo 2^32 and bounds are not checked.
`include "multidim_array_address_calc_assert.svh"

module multidim_array_address_calc #(
   parameter int MAX_ARRAYS = mdaac_pkg::MAX_ARRAYS_DEF,
   parameter int MAX_DIMS   = mdaac_pkg::MAX_DIMS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mdaac_pkg::CMD_W-1:0]          req_command,
   input  logic [mdaac_pkg::ID_W-1:0]           req_array_id,
   input  logic [mdaac_pkg::DNUM_W-1:0]         req_dim_number,
   input  logic signed [mdaac_pkg::WORD_W-1:0]  req_base_address,
   input  logic [mdaac_pkg::SIZE_W-1:0]         req_element_size,
   input  logic [mdaac_pkg::DNUM_W-1:0]         req_dim_count,
   input  logic signed [mdaac_pkg::WORD_W-1:0]  req_lower_bound,
   input  logic signed [mdaac_pkg::WORD_W-1:0]  req_upper_bound,
   input  logic signed [mdaac_pkg::WORD_W-1:0]  req_index_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mdaac_pkg::ID_W-1:0]           rsp_ref_array,
   output logic signed [mdaac_pkg::WORD_W-1:0]  rsp_element_address
);

   localparam int WW      = mdaac_pkg::WORD_W;
   localparam int SW      = mdaac_pkg::SIZE_W;
   localparam int IW      = mdaac_pkg::ID_W;
   localparam int NW      = mdaac_pkg::DNUM_W;
   localparam int SLOT_W  = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
   localparam int POS_W   = $clog2(MAX_DIMS + 1);
   localparam int DIDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int BND_N   = MAX_ARRAYS * MAX_DIMS;
   localparam int BA_W    = (BND_N > 1) ? $clog2(BND_N) : 1;
   localparam int HDR_W   = WW + SW + POS_W;
   localparam int BND_W   = 2 * WW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_LOOKUP,
      ST_MUL,
      ST_ACC,
      ST_SCALE,
      ST_ADDR
   } state_type;

   // Array id to table slot, reduced modulo MAX_ARRAYS at elaboration.
   logic [SLOT_W-1:0] slot_lut [mdaac_pkg::IDS_NUM];
   for (genvar g = 0; g < mdaac_pkg::IDS_NUM; g++) begin : g_slot
      localparam int SlotVal = g % MAX_ARRAYS;
      assign slot_lut[g] = SLOT_W'(SlotVal);
   end

   state_type            state_ff, state_in;
   logic [WW-1:0]        accum_ff, accum_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [WW-1:0]        rel_ff, rel_in;
   logic [WW-1:0]        ext_ff, ext_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        rsp_id_ff, rsp_id_in;
   logic [WW-1:0]        rsp_addr_ff, rsp_addr_in;

   mdaac_pkg::cmd_type   cmd_ff;
   logic [IW-1:0]        id_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [NW-1:0]        dnum_ff;
   logic [WW-1:0]        base_ff;
   logic [SW-1:0]        size_ff;
   logic [POS_W-1:0]     cnt_ff;
   logic [WW-1:0]        lo_ff;
   logic [WW-1:0]        hi_ff;
   logic [WW-1:0]        idx_ff;

   logic                 accept;
   logic [SLOT_W-1:0]    req_slot;
   logic [POS_W-1:0]     cnt_sat;
   logic [DIDX_W-1:0]    rd_didx;
   logic [NW-1:0]        dnum_m1;
   logic                 dnum_ok;

   logic                 hdr_we, bnd_we;
   logic [HDR_W-1:0]     hdr_wdata, hdr_rdata;
   logic [BND_W-1:0]     bnd_wdata, bnd_rdata;
   logic [BA_W-1:0]      bnd_waddr, bnd_raddr;
   logic [WW-1:0]        base_rd, lo_rd, hi_rd;
   logic [SW-1:0]        size_rd;
   logic [POS_W-1:0]     dims_rd, dims_eff, pos_inc;
   logic                 ref_done;

   mdaac_pkg::mul_req_type mul_req;
   logic [WW-1:0]          mul_prod;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_slot  = slot_lut[req_array_id];

   // Saturate the dimension count to 1..MAX_DIMS.
   always_comb begin
      if (req_dim_count == '0) begin
         cnt_sat = POS_W'(1);
      end else if (req_dim_count > NW'(MAX_DIMS)) begin
         cnt_sat = POS_W'(MAX_DIMS);
      end else begin
         cnt_sat = req_dim_count[POS_W-1:0];
      end
   end

   // Bounds entry of the current dimension, held at the last one.
   assign rd_didx = (pos_ff >= POS_W'(MAX_DIMS)) ? DIDX_W'(MAX_DIMS - 1)
                                                  : pos_ff[DIDX_W-1:0];
   assign bnd_raddr = BA_W'(req_slot) * BA_W'(MAX_DIMS) + BA_W'(rd_didx);

   assign dnum_m1   = dnum_ff - NW'(1);
   assign dnum_ok   = (dnum_ff != '0) && (dnum_ff <= NW'(MAX_DIMS));
   assign bnd_waddr = BA_W'(slot_ff) * BA_W'(MAX_DIMS) + BA_W'(dnum_m1[DIDX_W-1:0]);

   assign hdr_wdata = {base_ff, size_ff, cnt_ff};
   assign bnd_wdata = {lo_ff, hi_ff};
   assign {base_rd, size_rd, dims_rd} = hdr_rdata;
   assign {lo_rd, hi_rd} = bnd_rdata;

   mdaac_ram #(
      .WIDTH (HDR_W),
      .DEPTH (MAX_ARRAYS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (slot_ff),
      .wr_data (hdr_wdata),
      .rd_en   (accept),
      .rd_addr (req_slot),
      .rd_data (hdr_rdata)
   );

   mdaac_ram #(
      .WIDTH (BND_W),
      .DEPTH (BND_N)
   ) u_bnd_ram (
      .clock   (clock),
      .wr_en   (bnd_we),
      .wr_addr (bnd_waddr),
      .wr_data (bnd_wdata),
      .rd_en   (accept),
      .rd_addr (bnd_raddr),
      .rd_data (bnd_rdata)
   );

   mdaac_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (mul_prod)
   );

   assign dims_eff = (dims_rd == '0) ? POS_W'(1) : dims_rd;
   assign pos_inc  = pos_ff + POS_W'(1);
   assign ref_done = (pos_inc >= dims_eff) || (pos_inc >= POS_W'(MAX_DIMS));

   always_comb begin
      state_in     = state_ff;
      accum_in     = accum_ff;
      pos_in       = pos_ff;
      rel_in       = rel_ff;
      ext_in       = ext_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_addr_in  = rsp_addr_ff;
      hdr_we       = 1'b0;
      bnd_we       = 1'b0;
      mul_req.en   = 1'b0;
      mul_req.a    = accum_ff;
      mul_req.b    = ext_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == mdaac_pkg::CMD_INDEX) ? ST_LOOKUP : ST_WRITE;
            end
         end
         ST_WRITE: begin
            case (cmd_ff)
               mdaac_pkg::CMD_HEADER: begin
                  hdr_we   = 1'b1;
                  accum_in = '0;
                  pos_in   = '0;
               end
               mdaac_pkg::CMD_BOUNDS: begin
                  bnd_we   = dnum_ok;
                  accum_in = '0;
                  pos_in   = '0;
               end
               default: ;
            endcase
            state_in = ST_IDLE;
         end
         ST_LOOKUP: begin
            rel_in   = idx_ff - lo_rd;
            ext_in   = hi_rd - lo_rd + WW'(1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_req.en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            accum_in = (pos_ff == '0) ? rel_ff : mul_prod + rel_ff;
            pos_in   = pos_inc;
            state_in = ref_done ? ST_SCALE : ST_IDLE;
         end
         ST_SCALE: begin
            mul_req.en = 1'b1;
            mul_req.a  = {1'b0, size_rd};
            mul_req.b  = accum_ff;
            state_in   = ST_ADDR;
         end
         ST_ADDR: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_addr_in  = base_rd + mul_prod;
               accum_in     = '0;
               pos_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accum_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rel_ff      <= rel_in;
      ext_ff      <= ext_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_addr_ff <= rsp_addr_in;
      if (accept) begin
         cmd_ff  <= mdaac_pkg::cmd_type'(req_command);
         id_ff   <= req_array_id;
         slot_ff <= req_slot;
         dnum_ff <= req_dim_number;
         base_ff <= req_base_address;
         size_ff <= req_element_size;
         cnt_ff  <= cnt_sat;
         lo_ff   <= req_lower_bound;
         hi_ff   <= req_upper_bound;
         idx_ff  <= req_index_value;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ref_array       = rsp_id_ff;
   assign rsp_element_address = rsp_addr_ff;

   `MDAAC_ASSERT_NOW(a_pos_in_range, state_ff == ST_IDLE, pos_ff < POS_W'(MAX_DIMS), "dimension position out of range while idle")
   `MDAAC_ASSERT_NEXT(a_write_clears, accept && (req_command == mdaac_pkg::CMD_HEADER || req_command == mdaac_pkg::CMD_BOUNDS), ##1 (pos_ff == '0 && accum_ff == '0), "descriptor write did not abandon the reference")
   `MDAAC_ASSERT_NOW(a_rsp_from_addr, $rose(rsp_valid), $past(state_ff == ST_ADDR), "result raised outside the address step")
   `MDAAC_ASSERT_NEXT(a_scale_after_done, state_ff == ST_SCALE, state_ff == ST_ADDR, "scale step not followed by address step")

endmodule
